// ----- rtl/rsi_pkg.sv -----
// shared types for the ray / segment intersection pipeline
// no dependencies; imported by rsi_front, rsi_divider, rsi_place and ray_segment_intersection_top
`default_nettype none

package rsi_pkg;

    // control that travels beside the payload from stage to stage
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } rsi_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/rsi_in_if.sv -----
// query channel: valid/ready handshake carrying one segment and one ray
// no dependencies
`default_nettype none

interface rsi_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic signed [COORD_BITS-1:0] ray_origin_x;
    logic signed [COORD_BITS-1:0] ray_origin_y;
    logic signed [COORD_BITS-1:0] ray_toward_x;
    logic signed [COORD_BITS-1:0] ray_toward_y;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               ray_origin_x, ray_origin_y, ray_toward_x, ray_toward_y,
        input  ready
    );

    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               ray_origin_x, ray_origin_y, ray_toward_x, ray_toward_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rsi_out_if.sv -----
// result channel: valid/ready handshake carrying hit flag and crossing point
// no dependencies
`default_nettype none

interface rsi_out_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (
        output valid, hit, point_x, point_y,
        input  ready
    );

    modport sink (
        input  valid, hit, point_x, point_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rsi_front.sv -----
// setup stages: differences, cross products, cross terms, magnitudes, range test
// depends on rsi_pkg
`default_nettype none

module rsi_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS-1:0] x2,
    input  logic signed [COORD_BITS-1:0] y2,
    input  logic signed [COORD_BITS-1:0] x3,
    input  logic signed [COORD_BITS-1:0] y3,
    input  logic signed [COORD_BITS-1:0] x4,
    input  logic signed [COORD_BITS-1:0] y4,
    output rsi_pkg::rsi_ctl_t            out_ctl,
    input  logic                         out_ready,
    output logic [2*COORD_BITS+2:0]      out_anum,
    output logic [2*COORD_BITS+2:0]      out_aden,
    output logic [COORD_BITS:0]          out_mag_x,
    output logic [COORD_BITS:0]          out_mag_y,
    output logic signed [COORD_BITS-1:0] out_base_x,
    output logic signed [COORD_BITS-1:0] out_base_y
);
    import rsi_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int P  = 2 * D;
    localparam int W  = P + 1;
    localparam int NS = 5;

    // handshake
    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] ld;

    // stage 0: differences
    logic signed [D-1:0] dx12_reg, dy34_reg, dy12_reg, dx34_reg, dx13_reg, dy13_reg;
    logic signed [D-1:0] dx12_next, dy34_next, dy12_next, dx34_next, dx13_next, dy13_next;
    logic signed [C-1:0] base_x_reg [NS];
    logic signed [C-1:0] base_y_reg [NS];

    // stage 1: products and segment direction
    logic signed [P-1:0] pden_a_reg, pden_b_reg, pnt_a_reg, pnt_b_reg, pnu_a_reg, pnu_b_reg;
    logic signed [P-1:0] pden_a_next, pden_b_next, pnt_a_next, pnt_b_next;
    logic signed [P-1:0] pnu_a_next, pnu_b_next;
    logic [D-1:0]        mag_x_reg [1:NS-1];
    logic [D-1:0]        mag_y_reg [1:NS-1];
    logic                neg_x_reg [1:NS-1];
    logic                neg_y_reg [1:NS-1];
    logic [D-1:0]        mag_x_next, mag_y_next;

    // stage 2: cross terms
    logic signed [W-1:0] den_reg, nt_reg, nu_reg;
    logic signed [W-1:0] den_next, nt_next, nu_next;

    // stage 3: magnitudes and sign tests, stage 4: t < 1 test
    logic [W-1:0] aden_reg [3:4];
    logic [W-1:0] anum_reg [3:4];
    logic [W-1:0] aden_next, anum_next;
    logic         hit_pre_reg, hit_pre_next;
    logic         hit_reg, hit_next;

    always_comb
    begin
        rdy[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[0] = rdy[0] && in_valid;
        for (int k = 1; k < NS; k++)
        begin
            ld[k] = rdy[k] && vld_reg[k-1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        dx12_next = D'(x1) - D'(x2);
        dy34_next = D'(y3) - D'(y4);
        dy12_next = D'(y1) - D'(y2);
        dx34_next = D'(x3) - D'(x4);
        dx13_next = D'(x1) - D'(x3);
        dy13_next = D'(y1) - D'(y3);

        pden_a_next = P'(dx12_reg) * P'(dy34_reg);
        pden_b_next = P'(dy12_reg) * P'(dx34_reg);
        pnt_a_next  = P'(dx13_reg) * P'(dy34_reg);
        pnt_b_next  = P'(dy13_reg) * P'(dx34_reg);
        pnu_a_next  = P'(dx12_reg) * P'(dy13_reg);
        pnu_b_next  = P'(dy12_reg) * P'(dx13_reg);
        // segment direction is x2 - x1 = -(x1 - x2)
        mag_x_next  = dx12_reg[D-1] ? D'(-dx12_reg) : D'(dx12_reg);
        mag_y_next  = dy12_reg[D-1] ? D'(-dy12_reg) : D'(dy12_reg);

        den_next = W'(pden_a_reg) - W'(pden_b_reg);
        nt_next  = W'(pnt_a_reg) - W'(pnt_b_reg);
        nu_next  = W'(pnu_a_reg) - W'(pnu_b_reg);

        aden_next = den_reg[W-1] ? W'(-den_reg) : W'(den_reg);
        anum_next = nt_reg[W-1] ? W'(-nt_reg) : W'(nt_reg);
        // t > 0 and u > 0, with u = -num_u / den
        hit_pre_next = (|den_reg) && (|nt_reg) && (|nu_reg)
                    && (nt_reg[W-1] == den_reg[W-1])
                    && (nu_reg[W-1] != den_reg[W-1]);

        hit_next = hit_pre_reg && (anum_reg[3] < aden_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            dx12_reg      <= dx12_next;
            dy34_reg      <= dy34_next;
            dy12_reg      <= dy12_next;
            dx34_reg      <= dx34_next;
            dx13_reg      <= dx13_next;
            dy13_reg      <= dy13_next;
            base_x_reg[0] <= x1;
            base_y_reg[0] <= y1;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (ld[k])
            begin
                base_x_reg[k] <= base_x_reg[k-1];
                base_y_reg[k] <= base_y_reg[k-1];
            end
        end
        if (ld[1])
        begin
            pden_a_reg   <= pden_a_next;
            pden_b_reg   <= pden_b_next;
            pnt_a_reg    <= pnt_a_next;
            pnt_b_reg    <= pnt_b_next;
            pnu_a_reg    <= pnu_a_next;
            pnu_b_reg    <= pnu_b_next;
            mag_x_reg[1] <= mag_x_next;
            mag_y_reg[1] <= mag_y_next;
            neg_x_reg[1] <= !dx12_reg[D-1];
            neg_y_reg[1] <= !dy12_reg[D-1];
        end
        for (int k = 2; k < NS; k++)
        begin
            if (ld[k])
            begin
                mag_x_reg[k] <= mag_x_reg[k-1];
                mag_y_reg[k] <= mag_y_reg[k-1];
                neg_x_reg[k] <= neg_x_reg[k-1];
                neg_y_reg[k] <= neg_y_reg[k-1];
            end
        end
        if (ld[2])
        begin
            den_reg <= den_next;
            nt_reg  <= nt_next;
            nu_reg  <= nu_next;
        end
        if (ld[3])
        begin
            aden_reg[3] <= aden_next;
            anum_reg[3] <= anum_next;
            hit_pre_reg <= hit_pre_next;
        end
        if (ld[4])
        begin
            aden_reg[4] <= aden_reg[3];
            anum_reg[4] <= anum_reg[3];
            hit_reg     <= hit_next;
        end
    end

    assign out_ctl.valid = vld_reg[NS-1];
    assign out_ctl.hit   = hit_reg;
    assign out_ctl.neg_x = neg_x_reg[NS-1];
    assign out_ctl.neg_y = neg_y_reg[NS-1];
    assign out_anum      = anum_reg[4];
    assign out_aden      = aden_reg[4];
    assign out_mag_x     = mag_x_reg[NS-1];
    assign out_mag_y     = mag_y_reg[NS-1];
    assign out_base_x    = base_x_reg[NS-1];
    assign out_base_y    = base_y_reg[NS-1];

    // a hit always leaves a usable divisor with 0 < t < 1
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ctl.valid && out_ctl.hit |-> (out_aden != '0) && (out_anum < out_aden))
        else $error("hit without 0 < t < 1");

endmodule

`default_nettype wire

// ----- rtl/rsi_divider.sv -----
// pipelined restoring divider: floor(anum * mag / aden) for x and y, one bit a stage
// depends on rsi_pkg
`default_nettype none

module rsi_divider #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsi_pkg::rsi_ctl_t            in_ctl,
    output logic                         in_ready,
    input  logic [2*COORD_BITS+2:0]      in_anum,
    input  logic [2*COORD_BITS+2:0]      in_aden,
    input  logic [COORD_BITS:0]          in_mag_x,
    input  logic [COORD_BITS:0]          in_mag_y,
    input  logic signed [COORD_BITS-1:0] in_base_x,
    input  logic signed [COORD_BITS-1:0] in_base_y,
    output rsi_pkg::rsi_ctl_t            out_ctl,
    input  logic                         out_ready,
    output logic [COORD_BITS:0]          out_q_x,
    output logic [COORD_BITS:0]          out_q_y,
    output logic signed [COORD_BITS-1:0] out_base_x,
    output logic signed [COORD_BITS-1:0] out_base_y
);
    import rsi_pkg::*;

    localparam int C = COORD_BITS;
    localparam int D = C + 1;
    localparam int W = 2 * D + 1;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [D-1:0] q;
    } step_t;

    // one multiply-by-two step with the next multiplier bit folded in;
    // the partial sum stays below three divisors, so at most two come off
    function automatic step_t div_step(input step_t cur, input logic take,
                                       input logic [W-1:0] num,
                                       input logic [W-1:0] den);
        logic [W+1:0] r;
        logic [W+1:0] den1;
        logic [W+1:0] den2;
        step_t        nxt;
        den1     = (W+2)'(den);
        den2     = {1'b0, den, 1'b0};
        r        = {1'b0, cur.rem, 1'b0} + (take ? (W+2)'(num) : '0);
        nxt.q    = {cur.q[D-2:0], 1'b0};
        nxt.rem  = W'(r);
        if (r >= den2)
        begin
            nxt.rem = W'(r - den2);
            nxt.q   = nxt.q + D'(2);
        end
        else if (r >= den1)
        begin
            nxt.rem = W'(r - den1);
            nxt.q   = nxt.q + D'(1);
        end
        return nxt;
    endfunction

    rsi_ctl_t            ctl_reg    [D];
    step_t               st_x_reg   [D];
    step_t               st_y_reg   [D];
    logic [W-1:0]        anum_reg   [D];
    logic [W-1:0]        aden_reg   [D];
    logic [D-1:0]        mag_x_reg  [D];
    logic [D-1:0]        mag_y_reg  [D];
    logic signed [C-1:0] base_x_reg [D];
    logic signed [C-1:0] base_y_reg [D];

    rsi_ctl_t            src_ctl    [D];
    step_t               src_x      [D];
    step_t               src_y      [D];
    logic [W-1:0]        src_anum   [D];
    logic [W-1:0]        src_aden   [D];
    logic [D-1:0]        src_mag_x  [D];
    logic [D-1:0]        src_mag_y  [D];
    logic signed [C-1:0] src_base_x [D];
    logic signed [C-1:0] src_base_y [D];
    step_t               nx_x       [D];
    step_t               nx_y       [D];

    logic [D:0] rdy;
    logic [D-1:0] ld;

    for (genvar k = 0; k < D; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign src_ctl[k]    = in_ctl;
            assign src_x[k]      = step_t'('0);
            assign src_y[k]      = step_t'('0);
            assign src_anum[k]   = in_anum;
            assign src_aden[k]   = in_aden;
            assign src_mag_x[k]  = in_mag_x;
            assign src_mag_y[k]  = in_mag_y;
            assign src_base_x[k] = in_base_x;
            assign src_base_y[k] = in_base_y;
        end
        else
        begin : g_rest
            assign src_ctl[k]    = ctl_reg[k-1];
            assign src_x[k]      = st_x_reg[k-1];
            assign src_y[k]      = st_y_reg[k-1];
            assign src_anum[k]   = anum_reg[k-1];
            assign src_aden[k]   = aden_reg[k-1];
            assign src_mag_x[k]  = mag_x_reg[k-1];
            assign src_mag_y[k]  = mag_y_reg[k-1];
            assign src_base_x[k] = base_x_reg[k-1];
            assign src_base_y[k] = base_y_reg[k-1];
        end
        // msb of the multiplier first
        assign nx_x[k] = div_step(src_x[k], src_mag_x[k][D-1-k], src_anum[k], src_aden[k]);
        assign nx_y[k] = div_step(src_y[k], src_mag_y[k][D-1-k], src_anum[k], src_aden[k]);
    end

    always_comb
    begin
        rdy[D] = out_ready;
        for (int k = D - 1; k >= 0; k--)
        begin
            rdy[k] = !ctl_reg[k].valid || rdy[k+1];
        end
        for (int k = 0; k < D; k++)
        begin
            ld[k] = rdy[k] && src_ctl[k].valid;
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < D; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < D; k++)
            begin
                if (rdy[k])
                begin
                    ctl_reg[k] <= src_ctl[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < D; k++)
        begin
            if (ld[k])
            begin
                st_x_reg[k]   <= nx_x[k];
                st_y_reg[k]   <= nx_y[k];
                anum_reg[k]   <= src_anum[k];
                aden_reg[k]   <= src_aden[k];
                mag_x_reg[k]  <= src_mag_x[k];
                mag_y_reg[k]  <= src_mag_y[k];
                base_x_reg[k] <= src_base_x[k];
                base_y_reg[k] <= src_base_y[k];
            end
        end
    end

    assign out_ctl    = ctl_reg[D-1];
    assign out_q_x    = st_x_reg[D-1].q;
    assign out_q_y    = st_y_reg[D-1].q;
    assign out_base_x = base_x_reg[D-1];
    assign out_base_y = base_y_reg[D-1];

    // the remainder never reaches the divisor on a live hit
    a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[D-1].valid && ctl_reg[D-1].hit
            |-> (st_x_reg[D-1].rem < aden_reg[D-1]) && (anum_reg[D-1] < aden_reg[D-1]))
        else $error("x remainder out of range");

    a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[D-1].valid && ctl_reg[D-1].hit |-> st_y_reg[D-1].rem < aden_reg[D-1])
        else $error("y remainder out of range");

    // with t < 1 the offset stays inside the segment's extent
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[D-1].valid && ctl_reg[D-1].hit
            |-> (st_x_reg[D-1].q <= mag_x_reg[D-1]) && (st_y_reg[D-1].q <= mag_y_reg[D-1]))
        else $error("offset beyond segment");

endmodule

`default_nettype wire

// ----- rtl/rsi_place.sv -----
// output stage: start point plus signed offset, zeroed on a miss, held for the sink
// depends on rsi_pkg and rsi_out_if
`default_nettype none

module rsi_place #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsi_pkg::rsi_ctl_t            in_ctl,
    output logic                         in_ready,
    input  logic [COORD_BITS:0]          q_x,
    input  logic [COORD_BITS:0]          q_y,
    input  logic signed [COORD_BITS-1:0] base_x,
    input  logic signed [COORD_BITS-1:0] base_y,
    rsi_out_if.source                    result
);
    import rsi_pkg::*;

    localparam int C = COORD_BITS;

    logic         vld_reg;
    logic         hit_reg;
    logic [C-1:0] px_reg, py_reg;
    logic [C-1:0] px_next, py_next;
    logic         rdy;

    assign rdy      = !vld_reg || result.ready;
    assign in_ready = rdy;

    always_comb
    begin
        px_next = '0;
        py_next = '0;
        if (in_ctl.hit)
        begin
            px_next = in_ctl.neg_x ? C'(base_x) - C'(q_x) : C'(base_x) + C'(q_x);
            py_next = in_ctl.neg_y ? C'(base_y) - C'(q_y) : C'(base_y) + C'(q_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (rdy)
        begin
            vld_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_ctl.valid)
        begin
            hit_reg <= in_ctl.hit;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
    end

    assign result.valid   = vld_reg;
    assign result.hit     = hit_reg;
    assign result.point_x = px_reg;
    assign result.point_y = py_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |-> (result.point_x == '0) && (result.point_y == '0))
        else $error("miss with nonzero point");

endmodule

`default_nettype wire

// ----- rtl/ray_segment_intersection_top.sv -----
// channel   side   beat contents
// query     in     seg_start_x/y, seg_end_x/y, ray_origin_x/y, ray_toward_x/y
// result    out    hit, point_x, point_y
//
// one beat per clock in and out while result does not stall; the stages are:
// five setup stages, COORD_BITS + 1 divide stages (one quotient bit each), one output
// stage. each stage carries its own valid bit and loads when empty or moving on, so a
// stall on result first fills bubbles before query sees ready drop.
// rst_n clears the valid bits (and the divider's whole control words) only; payload registers are not reset.
// depends on rsi_pkg, rsi_in_if, rsi_out_if, rsi_front, rsi_divider, rsi_place
`default_nettype none

module ray_segment_intersection_top #(
    parameter int COORD_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rsi_in_if.sink    query,
    rsi_out_if.source result
);
    import rsi_pkg::*;

    localparam int C = COORD_BITS;
    localparam int D = C + 1;
    localparam int W = 2 * D + 1;

    rsi_ctl_t            front_ctl;
    logic                front_ready;
    logic [W-1:0]        front_anum, front_aden;
    logic [D-1:0]        front_mag_x, front_mag_y;
    logic signed [C-1:0] front_base_x, front_base_y;

    rsi_ctl_t            div_ctl;
    logic                div_ready;
    logic [D-1:0]        div_q_x, div_q_y;
    logic signed [C-1:0] div_base_x, div_base_y;

    rsi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (query.valid),
        .in_ready   (query.ready),
        .x1         (query.seg_start_x),
        .y1         (query.seg_start_y),
        .x2         (query.seg_end_x),
        .y2         (query.seg_end_y),
        .x3         (query.ray_origin_x),
        .y3         (query.ray_origin_y),
        .x4         (query.ray_toward_x),
        .y4         (query.ray_toward_y),
        .out_ctl    (front_ctl),
        .out_ready  (front_ready),
        .out_anum   (front_anum),
        .out_aden   (front_aden),
        .out_mag_x  (front_mag_x),
        .out_mag_y  (front_mag_y),
        .out_base_x (front_base_x),
        .out_base_y (front_base_y)
    );

    rsi_divider #(
        .COORD_BITS (COORD_BITS)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (front_ctl),
        .in_ready   (front_ready),
        .in_anum    (front_anum),
        .in_aden    (front_aden),
        .in_mag_x   (front_mag_x),
        .in_mag_y   (front_mag_y),
        .in_base_x  (front_base_x),
        .in_base_y  (front_base_y),
        .out_ctl    (div_ctl),
        .out_ready  (div_ready),
        .out_q_x    (div_q_x),
        .out_q_y    (div_q_y),
        .out_base_x (div_base_x),
        .out_base_y (div_base_y)
    );

    rsi_place #(
        .COORD_BITS (COORD_BITS)
    ) u_place (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (div_ctl),
        .in_ready (div_ready),
        .q_x      (div_q_x),
        .q_y      (div_q_y),
        .base_x   (div_base_x),
        .base_y   (div_base_y),
        .result   (result)
    );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for ray_segment_intersection_top: directed and random segment / ray queries
// checked against a behavioral predictor of the crossing test and crossing point
// depends on rsi_in_if, rsi_out_if and the ray_segment_intersection_top rtl
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 2;
    localparam int CROSS_W    = 2 * DIFF_W + 1;
    localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
    localparam int BUILD_SPAN = (1 << (COORD_BITS - 2)) - 400;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_end_x;
        coord_t seg_end_y;
        coord_t ray_origin_x;
        coord_t ray_origin_y;
        coord_t ray_toward_x;
        coord_t ray_toward_y;
    } query_t;

    typedef struct packed {
        logic   hit;
        coord_t point_x;
        coord_t point_y;
    } crossing_t;

    logic clk;
    logic rst_n;

    rsi_in_if  #(.COORD_BITS(COORD_BITS)) query_ch ();
    rsi_out_if #(.COORD_BITS(COORD_BITS)) result_ch ();

    ray_segment_intersection_top #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    crossing_t pending_crossings[$];
    int        mismatches = 0;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // exact crossing test: sign and magnitude compares, one divide per axis for the point
    function automatic crossing_t predict_crossing(query_t q);
        logic signed [DIFF_W-1:0]  d12x, d12y, d34x, d34y, d13x, d13y, dx, dy;
        logic signed [CROSS_W-1:0] den, num_t, num_u;
        logic [CROSS_W-1:0]        mag_den, mag_t;
        logic [DIFF_W-1:0]         mag_dx, mag_dy;
        logic [CROSS_W+DIFF_W-1:0] quot_x, quot_y;
        logic signed [DIFF_W-1:0]  px, py;
        crossing_t                 r;
        d12x = q.seg_start_x - q.seg_end_x;
        d12y = q.seg_start_y - q.seg_end_y;
        d34x = q.ray_origin_x - q.ray_toward_x;
        d34y = q.ray_origin_y - q.ray_toward_y;
        d13x = q.seg_start_x - q.ray_origin_x;
        d13y = q.seg_start_y - q.ray_origin_y;
        den   = d12x * d34y - d12y * d34x;
        num_t = d13x * d34y - d13y * d34x;
        num_u = d12x * d13y - d12y * d13x;
        r = '0;
        if (den != 0)
        begin
            mag_den = den[CROSS_W-1] ? -den : den;
            mag_t   = num_t[CROSS_W-1] ? -num_t : num_t;
            // 0 < t < 1 and u > 0, all strict
            if (num_t != 0 && num_t[CROSS_W-1] == den[CROSS_W-1] && mag_t < mag_den &&
                num_u != 0 && num_u[CROSS_W-1] != den[CROSS_W-1])
            begin
                dx = q.seg_end_x - q.seg_start_x;
                dy = q.seg_end_y - q.seg_start_y;
                mag_dx = dx[DIFF_W-1] ? -dx : dx;
                mag_dy = dy[DIFF_W-1] ? -dy : dy;
                quot_x = (mag_t * mag_dx) / mag_den;
                quot_y = (mag_t * mag_dy) / mag_den;
                px = dx[DIFF_W-1] ? q.seg_start_x - $signed(quot_x[DIFF_W-1:0])
                                  : q.seg_start_x + $signed(quot_x[DIFF_W-1:0]);
                py = dy[DIFF_W-1] ? q.seg_start_y - $signed(quot_y[DIFF_W-1:0])
                                  : q.seg_start_y + $signed(quot_y[DIFF_W-1:0]);
                r.hit     = 1'b1;
                r.point_x = px[COORD_BITS-1:0];
                r.point_y = py[COORD_BITS-1:0];
            end
        end
        return r;
    endfunction

    function automatic query_t make_query(int x1, int y1, int x2, int y2,
                                          int x3, int y3, int x4, int y4);
        query_t q;
        q.seg_start_x  = x1[COORD_BITS-1:0];
        q.seg_start_y  = y1[COORD_BITS-1:0];
        q.seg_end_x    = x2[COORD_BITS-1:0];
        q.seg_end_y    = y2[COORD_BITS-1:0];
        q.ray_origin_x = x3[COORD_BITS-1:0];
        q.ray_origin_y = y3[COORD_BITS-1:0];
        q.ray_toward_x = x4[COORD_BITS-1:0];
        q.ray_toward_y = y4[COORD_BITS-1:0];
        return q;
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 0;
            3:       return -1;
            default: return pick(COORD_MIN, COORD_MAX);
        endcase
    endfunction

    // nearly half rays built to pass through the segment, the rest noise and near misses
    function automatic query_t random_query();
        int kind, s, x1, y1, x2, y2, ox, oy, px, py, tx, ty;
        kind = $urandom_range(99);
        if (kind >= 65 && kind < 80)
            return make_query(pick(-3, 3), pick(-3, 3), pick(-3, 3), pick(-3, 3),
                              pick(-3, 3), pick(-3, 3), pick(-3, 3), pick(-3, 3));
        if (kind >= 45 && kind < 65)
            return make_query(pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX),
                              pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX),
                              pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX),
                              pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX));
        if (kind >= 90)
            return make_query(extreme_coord(), extreme_coord(), extreme_coord(),
                              extreme_coord(), extreme_coord(), extreme_coord(),
                              extreme_coord(), extreme_coord());
        x1 = pick(-BUILD_SPAN, BUILD_SPAN);
        y1 = pick(-BUILD_SPAN, BUILD_SPAN);
        x2 = pick(-BUILD_SPAN, BUILD_SPAN);
        y2 = pick(-BUILD_SPAN, BUILD_SPAN);
        ox = pick(-BUILD_SPAN, BUILD_SPAN);
        oy = pick(-BUILD_SPAN, BUILD_SPAN);
        // near miss: aim at an endpoint, or start the ray on the segment
        if (kind >= 80)
            s = ($urandom_range(2) == 0) ? pick(1, 255) : 256 * int'($urandom_range(1));
        else
            s = pick(1, 255);
        px = x1 + ((x2 - x1) * s) / 256;
        py = y1 + ((y2 - y1) * s) / 256;
        if (kind >= 80 && $urandom_range(2) == 0)
            return make_query(x1, y1, x2, y2, px, py, pick(-BUILD_SPAN, BUILD_SPAN),
                              pick(-BUILD_SPAN, BUILD_SPAN));
        case ($urandom_range(2))
            0:
            begin
                tx = px;
                ty = py;
            end
            1:
            begin
                tx = ox + (px - ox) / 2;
                ty = oy + (py - oy) / 2;
            end
            default:
            begin
                tx = px + (px - ox) / 2;
                ty = py + (py - oy) / 2;
            end
        endcase
        if (tx == ox && ty == oy)
            tx = px;
        return make_query(x1, y1, x2, y2, ox, oy, tx, ty);
    endfunction

    task automatic send_query(query_t q);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct)
                query_ch.valid <= 1'b0;
            else
                break;
        end
        query_ch.seg_start_x  <= q.seg_start_x;
        query_ch.seg_start_y  <= q.seg_start_y;
        query_ch.seg_end_x    <= q.seg_end_x;
        query_ch.seg_end_y    <= q.seg_end_y;
        query_ch.ray_origin_x <= q.ray_origin_x;
        query_ch.ray_origin_y <= q.ray_origin_y;
        query_ch.ray_toward_x <= q.ray_toward_x;
        query_ch.ray_toward_y <= q.ray_toward_y;
        query_ch.valid        <= 1'b1;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        pending_crossings.insert(pending_crossings.size(), predict_crossing(q));
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        query_ch.valid <= 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct, int count, bit pause_midway);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_for_drain();
            send_query(random_query());
        end
        wait_for_drain();
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // plain crossing at the origin, then the same ray turned away
        send_query(make_query(0, -160, 0, 160, -160, 0, -80, 0));
        send_query(make_query(0, -160, 0, 160, -160, 0, -240, 0));
        // parallel, collinear, zero-length segment, ray with no direction
        send_query(make_query(0, 0, 160, 0, 0, 16, 16, 16));
        send_query(make_query(0, 0, 160, 0, -16, 0, 0, 0));
        send_query(make_query(32, 32, 32, 32, -160, 0, 160, 64));
        send_query(make_query(0, -160, 0, 160, -40, 7, -40, 7));
        // ray touches the first endpoint, the second endpoint, starts on the segment
        send_query(make_query(0, 0, 0, 160, -160, 0, -80, 0));
        send_query(make_query(0, -160, 0, 0, -160, 0, -80, 0));
        send_query(make_query(0, -160, 0, 160, 0, 0, 80, 0));
        // truncation toward zero on negative segment deltas
        send_query(make_query(100, -37, -7, 50, 0, -100, 3, 101));
        send_query(make_query(-5, 9, 11, -13, -20, -20, 1, 3));
        send_query(make_query(0, -1, 0, 1, -1, 0, 1, 0));
        // full-range coordinates
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                              COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        send_query(make_query(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                              COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN + 1));
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                              COORD_MAX, 0, COORD_MAX - 1, 0));
        send_query(make_query(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                              COORD_MIN, -1, COORD_MIN + 3, 1));
        send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        // toward point well past the segment
        send_query(make_query(-300, 500, 700, -900, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_query(make_query(-1, -1, 1, 1, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        run_random_phase(0, 0, 333, 1'b0);
    endtask

    task automatic test_sender_gaps();
        run_random_phase(63, 0, 333, 1'b0);
    endtask

    task automatic test_receiver_stalls();
        run_random_phase(0, 63, 333, 1'b0);
    endtask

    task automatic test_both_sides_idle();
        run_random_phase(35, 35, 333, 1'b1);
    endtask

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_crossings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: hit %0b point (%0d, %0d)",
                             result_ch.hit, result_ch.point_x, result_ch.point_y);
            end
            else
            begin
                want = pending_crossings.pop_front();
                if (result_ch.hit !== want.hit || result_ch.point_x !== want.point_x ||
                    result_ch.point_y !== want.point_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit %0b (%0d, %0d), got hit %0b (%0d, %0d)",
                                 want.hit, want.point_x, want.point_y,
                                 result_ch.hit, result_ch.point_x, result_ch.point_y);
                end
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        query_ch.valid        = 1'b0;
        query_ch.seg_start_x  = '0;
        query_ch.seg_start_y  = '0;
        query_ch.seg_end_x    = '0;
        query_ch.seg_end_y    = '0;
        query_ch.ray_origin_x = '0;
        query_ch.ray_origin_y = '0;
        query_ch.ray_toward_x = '0;
        query_ch.ray_toward_y = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();

        // let any stray beat surface before the verdict
        repeat (COORD_BITS + 20) @(posedge clk);
        if (mismatches == 0 && pending_crossings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rsi_pkg.sv
rtl/rsi_in_if.sv
rtl/rsi_out_if.sv
rtl/rsi_front.sv
rtl/rsi_divider.sv
rtl/rsi_place.sv
rtl/ray_segment_intersection_top.sv
tb/sv/testbench.sv
